// File: hdl/rpa_pkg.sv
package rpa_pkg;

  // Command codes carried on the input tuser
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Operation kinds queued between front and back
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Fixed field widths
  localparam int CFG_W   = 11;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 10;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 21;
  localparam int MR_W    = 10;
  localparam int QDEPTH  = 4;

  typedef logic [1:0] op_kind_t;

  // Status the back end reports to the top level
  typedef struct packed {
    logic init_done;
    logic nb_ready;
  } back_status_t;

endpackage

// File: hdl/rpa_fifo.sv
module rpa_fifo import rpa_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(QDEPTH);

  logic [DW-1:0] mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   fill_r;

  assign full  = (fill_r == (PW+1)'(QDEPTH));
  assign empty = (fill_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

// File: hdl/rpa_isqrt.sv
module rpa_isqrt import rpa_pkg::*; #(
  parameter int SQ_W = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SQ_W-1:0]         operand,
  output logic                    done,
  output logic [(SQ_W+1)/2-1:0]   root
);

  localparam int RB  = (SQ_W + 1) / 2;
  localparam int CW  = $clog2(RB + 1);
  localparam logic [SQ_W-1:0] BIT0 = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * (RB - 1));

  logic [SQ_W-1:0] rem_r;
  logic [SQ_W:0]   res_r;
  logic [SQ_W-1:0] bit_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [SQ_W:0]   trial;

  assign trial = res_r + {1'b0, bit_r};
  assign done  = done_r;
  assign root  = res_r[RB-1:0];

  // One result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= operand;
      res_r <= '0;
      bit_r <= BIT0;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r <= rem_r - trial[SQ_W-1:0];
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Count iterations and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/rpa_front.sv
module rpa_front import rpa_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic [1:0]                        cmd,
  input  logic [VAL_W-1:0]                  pix,
  input  logic [IDX_W-1:0]                  idx,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_h,
  output logic                              push,
  output logic [2+VAL_W+IDX_W+1+2*($clog2(MAX_DIM+1)-1)-1:0] push_data
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int HALF_W = DIM_W - 1;
  localparam int POS_W  = DIM_W + 1;

  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic             done_r, done_nxt;
  logic [POS_W-1:0] w_ext, h_ext, cx_ext, cy_ext;

  assign w_ext  = POS_W'(dim_w);
  assign h_ext  = POS_W'(dim_h);
  assign cx_ext = POS_W'(dim_w >> 1);
  assign cy_ext = POS_W'(dim_h >> 1);

  // Track raster position and classify the transaction
  always_comb begin
    logic [POS_W-1:0] c, rw, dx, dy;
    op_kind_t         kind;
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    push     = 1'b0;
    kind     = OP_PIXEL;
    dx       = '0;
    dy       = '0;
    c        = col_r;
    rw       = row_r;
    if (in_fire) begin
      unique case (cmd)
        CMD_PIXEL: begin
          if (!done_r) begin
            if (c >= w_ext) begin
              c  = '0;
              rw = rw + 1'b1;
            end
            if (rw >= h_ext) begin
              done_nxt = 1'b1;
            end else begin
              push = 1'b1;
              dx   = (c >= cx_ext) ? c - cx_ext : cx_ext - c;
              dy   = (rw >= cy_ext) ? rw - cy_ext : cy_ext - rw;
              c    = c + 1'b1;
              if (c >= w_ext) begin
                c  = '0;
                rw = rw + 1'b1;
                if (rw >= h_ext) done_nxt = 1'b1;
              end
            end
            col_nxt = c;
            row_nxt = rw;
          end
        end
        CMD_READ: begin
          push = 1'b1;
          kind = OP_READ;
        end
        CMD_CLEAR: begin
          push     = 1'b1;
          kind     = OP_CLEAR;
          col_nxt  = '0;
          row_nxt  = '0;
          done_nxt = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
    push_data = {kind, pix, idx, done_r, dx[HALF_W-1:0], dy[HALF_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// File: hdl/rpa_back.sv
module rpa_back import rpa_pkg::*; #(
  parameter int MAX_DIM  = 1024,
  parameter int NUM_BINS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_changed,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_h,
  input  logic                              q_empty,
  input  logic [2+VAL_W+IDX_W+1+2*($clog2(MAX_DIM+1)-1)-1:0] q_data,
  output logic                              q_pop,
  output back_status_t                      status,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [VAL_W-1:0]                  out_mean,
  output logic [CNT_W-1:0]                  out_count,
  output logic                              out_valid_bin,
  output logic [MR_W-1:0]                   out_max_radius,
  output logic                              out_frame
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int HALF_W = DIM_W - 1;
  localparam int SQ_W   = 2 * HALF_W + 1;
  localparam int RB     = (SQ_W + 1) / 2;
  localparam int BW     = $clog2(NUM_BINS);
  localparam int NBC_W  = $clog2(NUM_BINS + 1);
  localparam int NB_W   = (RB > NBC_W) ? RB : NBC_W;
  localparam int EW     = SUM_W + CNT_W;
  localparam int QW     = $clog2(VAL_W);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_NB_RT  = 4'd2;
  localparam logic [3:0] ST_PX_RT  = 4'd3;
  localparam logic [3:0] ST_PX_UPD = 4'd4;
  localparam logic [3:0] ST_RD_CHK = 4'd5;
  localparam logic [3:0] ST_RD_DIV = 4'd6;
  localparam logic [3:0] ST_RD_OUT = 4'd7;

  // Unpack the queued operation
  op_kind_t            q_kind;
  logic [VAL_W-1:0]    q_val;
  logic [IDX_W-1:0]    q_idx;
  logic                q_done;
  logic [HALF_W-1:0]   q_dx, q_dy;
  assign {q_kind, q_val, q_idx, q_done, q_dx, q_dy} = q_data;

  logic [3:0]          state_r;
  logic                init_done_r, nb_ok_r;
  logic [NB_W-1:0]     nb_r;
  logic [BW-1:0]       addr_r, clr_addr_r, rd_addr;
  logic [VAL_W-1:0]    val_r;
  logic                frame_r, vbin_r;
  logic [SUM_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [VAL_W-1:0]    quo_r;
  logic [QW-1:0]       step_r;

  // Squares feed the root unit straight from the queue head or the center
  logic [HALF_W-1:0]   sa, sb;
  logic [2*HALF_W-1:0] pa, pb;
  logic [SQ_W-1:0]     sq;
  logic                sqrt_start, sqrt_done;
  logic [RB-1:0]       root;

  assign sa = (state_r == ST_IDLE && !nb_ok_r) ? HALF_W'(dim_w >> 1) : q_dx;
  assign sb = (state_r == ST_IDLE && !nb_ok_r) ? HALF_W'(dim_h >> 1) : q_dy;
  assign pa = sa * sa;
  assign pb = sb * sb;
  assign sq = {1'b0, pa} + {1'b0, pb};

  assign sqrt_start = (state_r == ST_IDLE) && init_done_r &&
                      (!nb_ok_r || (!q_empty && q_kind == OP_PIXEL));

  rpa_isqrt #(.SQ_W(SQ_W)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand (sq),
    .done    (sqrt_done),
    .root    (root)
  );

  assign q_pop  = (state_r == ST_IDLE) && init_done_r && nb_ok_r && !q_empty;
  assign status = '{init_done: init_done_r, nb_ready: nb_ok_r};

  // Bin store: sum and count in one word
  logic [EW-1:0] mem [NUM_BINS];
  logic [EW-1:0] mem_q, wr_data;
  logic [BW-1:0] wr_addr;
  logic          mem_we;
  logic [SUM_W:0] sum_ext;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;

  assign sum_ext = {1'b0, mem_q[EW-1:CNT_W]} + (SUM_W+1)'(val_r);
  assign sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign cnt_new = (&mem_q[CNT_W-1:0]) ? mem_q[CNT_W-1:0] : mem_q[CNT_W-1:0] + 1'b1;

  always_comb begin
    priority case (state_r)
      ST_IDLE:  rd_addr = BW'(q_idx);
      ST_PX_RT: rd_addr = BW'(root);
      default:  rd_addr = addr_r;
    endcase
  end

  assign mem_we  = (state_r == ST_CLR) || (state_r == ST_PX_UPD);
  assign wr_addr = (state_r == ST_CLR) ? clr_addr_r : addr_r;
  assign wr_data = (state_r == ST_CLR) ? '0 : {sum_new, cnt_new};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  // Restoring divide: trial subtract of the shifted count
  logic [SUM_W:0] dshift;
  assign dshift = (SUM_W+1)'(cnt_r) << step_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      init_done_r <= 1'b0;
      nb_ok_r     <= 1'b0;
      clr_addr_r  <= '0;
      out_tvalid  <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && state_r != ST_RD_OUT) out_tvalid <= 1'b0;
      if (cfg_changed) nb_ok_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          if (clr_addr_r == BW'(NUM_BINS - 1)) begin
            clr_addr_r  <= '0;
            init_done_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (init_done_r && !nb_ok_r) begin
            // wait for the register writes to settle before sampling the center
            if (!cfg_changed) state_r <= ST_NB_RT;
          end else if (q_pop) begin
            val_r   <= q_val;
            frame_r <= q_done;
            addr_r  <= BW'(q_idx);
            priority case (q_kind)
              OP_PIXEL: state_r <= ST_PX_RT;
              OP_READ: begin
                if (32'(q_idx) < 32'(nb_r)) begin
                  vbin_r  <= 1'b1;
                  state_r <= ST_RD_CHK;
                end else begin
                  vbin_r  <= 1'b0;
                  quo_r   <= '0;
                  cnt_r   <= '0;
                  state_r <= ST_RD_OUT;
                end
              end
              OP_CLEAR: state_r <= ST_CLR;
              default:  state_r <= ST_IDLE;
            endcase
          end
        end
        ST_NB_RT: begin
          if (cfg_changed) begin
            state_r <= ST_IDLE;
          end else if (sqrt_done) begin
            nb_r    <= (32'(root) < NUM_BINS) ? NB_W'(root) : NB_W'(NUM_BINS);
            nb_ok_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_PX_RT: begin
          if (sqrt_done) begin
            addr_r  <= BW'(root);
            state_r <= (32'(root) < 32'(nb_r)) ? ST_PX_UPD : ST_IDLE;
          end
        end
        ST_PX_UPD: begin
          state_r <= ST_IDLE;
        end
        ST_RD_CHK: begin
          rem_r  <= mem_q[EW-1:CNT_W];
          cnt_r  <= mem_q[CNT_W-1:0];
          quo_r  <= '0;
          step_r <= QW'(VAL_W - 1);
          state_r <= (mem_q[CNT_W-1:0] == '0) ? ST_RD_OUT : ST_RD_DIV;
        end
        ST_RD_DIV: begin
          if ({1'b0, rem_r} >= dshift) begin
            rem_r         <= rem_r - dshift[SUM_W-1:0];
            quo_r[step_r] <= 1'b1;
          end
          step_r <= step_r - 1'b1;
          if (step_r == '0) state_r <= ST_RD_OUT;
        end
        ST_RD_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid     <= 1'b1;
            out_mean       <= quo_r;
            out_count      <= cnt_r;
            out_valid_bin  <= vbin_r;
            out_max_radius <= MR_W'(nb_r);
            out_frame      <= frame_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/radial_profile_accumulator.sv
// Radial profile of a magnitude image. Pixels (tuser 0) arrive in raster order; the block
// counts column and row, finds each pixel's radius bin as the integer root of its squared
// distance from (width/2, height/2) and adds the value to that bin's sum and count. A read
// (tuser 1) returns floor(sum/count) with the count, a flag for an in-range bin, the
// number of bins and a frame-complete flag; a clear (tuser 2) zeroes the bins and restarts
// the frame. A front stage takes transactions into a four-entry queue; the back end runs
// one at a time. A pixel's bin comes from the bit-serial root unit, and a pixel whose bin
// is out of range is skipped; a read of a filled bin uses the one-bit-per-cycle divider,
// then waits while the result side holds off; a clear and the pass after reset zero the
// bin memory, and no input is accepted during the pass after reset. A width or height
// write costs one root computation before the next transaction runs.
module radial_profile_accumulator import rpa_pkg::*; #(
  parameter int MAX_DIM  = 1024,
  parameter int NUM_BINS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // pixel_value[15:0], bin_index[25:16]
  input  logic [1:0]       in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // mean_value[15:0], bin_count[36:16],
                                       // max_radius[46:37], frame_complete[47]
  output logic             out_tuser,  // bin_valid[0]
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int HALF_W = DIM_W - 1;
  localparam int OP_W   = 2 + VAL_W + IDX_W + 1 + 2 * HALF_W;
  localparam int CMP_W  = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;

  // Configuration registers
  logic [CFG_W-1:0] width_r, height_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    width_r  <= width_r;
      endcase
    end
  end

  // Saturate dimensions to the supported range
  logic [DIM_W-1:0] dim_w, dim_h;
  always_comb begin
    if (CMP_W'(width_r) < CMP_W'(2))            dim_w = DIM_W'(2);
    else if (CMP_W'(width_r) > CMP_W'(MAX_DIM)) dim_w = DIM_W'(MAX_DIM);
    else                                        dim_w = DIM_W'(width_r);
    if (CMP_W'(height_r) < CMP_W'(2))            dim_h = DIM_W'(2);
    else if (CMP_W'(height_r) > CMP_W'(MAX_DIM)) dim_h = DIM_W'(MAX_DIM);
    else                                         dim_h = DIM_W'(height_r);
  end

  logic            push, q_full, q_empty, q_pop, in_fire;
  logic [OP_W-1:0] push_data, q_data;
  back_status_t    status;

  assign in_tready = !q_full && status.init_done;
  assign in_fire   = in_tvalid && in_tready;

  rpa_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cmd       (in_tuser),
    .pix       (in_tdata[15:0]),
    .idx       (in_tdata[25:16]),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .push      (push),
    .push_data (push_data)
  );

  rpa_fifo #(.DW(OP_W)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_data),
    .pop   (q_pop),
    .dout  (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  logic [VAL_W-1:0] mean;
  logic [CNT_W-1:0] count;
  logic             vbin, frame;
  logic [MR_W-1:0]  max_radius;

  rpa_back #(.MAX_DIM(MAX_DIM), .NUM_BINS(NUM_BINS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_changed    (cfg_we),
    .dim_w          (dim_w),
    .dim_h          (dim_h),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .status         (status),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_mean       (mean),
    .out_count      (count),
    .out_valid_bin  (vbin),
    .out_max_radius (max_radius),
    .out_frame      (frame)
  );

  assign out_tdata = {frame, max_radius, count, mean};
  assign out_tuser = vbin;

endmodule
